// ===== rtl/core/pfts_pkg.sv =====
// ----------------------------------------------------------------------------
// pfts_pkg: shared types and constants
// Slot and queue entry types, command bundle for the cell row, and codes of
// the priority frame transmit scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pfts_pkg;

  localparam int SLOTS           = 16;
  localparam int SLOT_W          = $clog2(SLOTS);
  localparam int PRIO_W          = 8;
  localparam int LEN_W           = 10;
  localparam int MAX_FRAME_BYTES = 512;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DONE    = 1'b1;

  typedef enum logic [2:0] {
    ST_QUEUED         = 3'd0,
    ST_QUEUED_STARTED = 3'd1,
    ST_REJECTED       = 3'd2,
    ST_DONE_STARTED   = 3'd3,
    ST_DONE_IDLE      = 3'd4
  } status_t;

  // One frame descriptor as it sits in a queue cell or in the transmitter.
  // The two_sends flag means the corrupted copy still has to go out first.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
    logic [LEN_W-1:0]  len;
    logic              reliable;
    logic              two_sends;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } q_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfts_cell.sv =====
// ----------------------------------------------------------------------------
// pfts_cell: one cell of the sorted queue
// Holds one descriptor. On insert it keeps its entry, takes the new one, or
// takes its left neighbor's; on pop it takes its right neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module pfts_cell
  import pfts_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire q_cmd_t cmd,
  input  wire entry_t left_ent,
  input  wire logic   left_keep,
  input  wire entry_t right_ent,
  output entry_t      ent,
  output logic        keep
);

  entry_t ent_next;

  // Entries of equal or higher priority stay ahead of the new one.
  assign keep = ent.valid && (ent.prio >= cmd.ent.prio);

  always_comb begin
    ent_next = ent;
    if (cmd.ins) begin
      if (!keep) begin
        ent_next = left_keep ? cmd.ent : left_ent;
      end
    end else if (cmd.pop) begin
      ent_next = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    ent.slot      <= ent_next.slot;
    ent.prio      <= ent_next.prio;
    ent.len       <= ent_next.len;
    ent.reliable  <= ent_next.reliable;
    ent.two_sends <= ent_next.two_sends;
  end

endmodule

`default_nettype wire

// ===== rtl/core/pfts_queue.sv =====
// ----------------------------------------------------------------------------
// pfts_queue: row of queue cells
// Sorted by descending priority, head in cell 0, equal priorities in arrival
// order.
// ----------------------------------------------------------------------------
`default_nettype none

module pfts_queue
  import pfts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire q_cmd_t     cmd,
  output entry_t          head,
  output logic [SLOTS-1:0] occ
);

  entry_t ent  [SLOTS];
  logic   keep [SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    entry_t left_ent;
    logic   left_keep;
    entry_t right_ent;

    if (i == 0) begin : g_first
      assign left_ent  = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_ent  = ent[i-1];
      assign left_keep = keep[i-1];
    end

    if (i == SLOTS - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    pfts_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left_ent  (left_ent),
      .left_keep (left_keep),
      .right_ent (right_ent),
      .ent       (ent[i]),
      .keep      (keep[i])
    );

    assign occ[i] = ent[i].valid;
  end

  assign head = ent[0];

endmodule

`default_nettype wire

// ===== rtl/core/priority_frame_transmit_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_frame_transmit_scheduler: transmit frame scheduler
// Allocates slots from a free map, keeps queued frames in a sorted row of
// cells and starts the queue head whenever the transmitter is free.
//
//  Channel  Dir  Signals                      Contents
//  s_axis   in   tvalid tready tdata tuser    enqueue request or completion
//  m_axis   out  tvalid tready tdata tuser    one result per transfer in
//
// An item passes through accept and queue insert, then a pop of the cell row
// when a frame starts, then the output load.
// The insert and the pop share the cell row, so they take separate steps.
// Reset leaves every slot free, the queue empty and the transmitter idle.
// A stalled output holds the finished result; the next transfer in is taken
// once that result has moved into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_frame_transmit_scheduler
  import pfts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // priority_req, qos, sends, frame_length
  input  wire logic [0:0]  s_axis_tuser,  // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // slot, tx_slot, tx_length, tx_corrupt
  output logic [2:0]       m_axis_tuser   // status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DONE
  } state_t;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

  state_t            state;
  logic [SLOTS-1:0]  free_map;
  logic              tx_busy;
  entry_t            cur;
  logic              from_enq;
  status_t           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [SLOT_W-1:0] res_tx_slot;
  logic [LEN_W-1:0]  res_tx_len;
  logic              res_tx_corrupt;

  logic              accept;
  logic              act;
  logic [PRIO_W-1:0] in_prio;
  logic              in_qos;
  logic [1:0]        in_sends;
  logic [LEN_W-1:0]  in_len;
  logic [LEN_W-1:0]  len_sat;
  entry_t            new_ent;
  entry_t            ret_ent;
  logic              any_free;
  logic [SLOT_W-1:0] free_idx;
  q_cmd_t            qcmd;
  entry_t            head;
  logic [SLOTS-1:0]  occ;

  assign act      = s_axis_tuser[0];
  assign in_prio  = s_axis_tdata[7:0];
  assign in_qos   = s_axis_tdata[8];
  assign in_sends = s_axis_tdata[10:9];
  assign in_len   = s_axis_tdata[20:11];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign len_sat = (in_len > MAX_LEN) ? MAX_LEN : in_len;

  // Lowest-numbered free slot.
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end
  assign any_free = |free_map;

  always_comb begin
    new_ent           = '0;
    new_ent.valid     = 1'b1;
    new_ent.slot      = free_idx;
    new_ent.prio      = in_prio;
    new_ent.len       = len_sat;
    new_ent.reliable  = in_qos;
    new_ent.two_sends = in_qos && in_sends[1];
  end

  // A frame coming back after its corrupted copy has one send left.
  always_comb begin
    ret_ent           = cur;
    ret_ent.valid     = 1'b1;
    ret_ent.two_sends = 1'b0;
  end

  always_comb begin
    qcmd.ins = accept && (((act == ACT_ENQUEUE) && any_free) ||
                          ((act == ACT_DONE) && tx_busy && cur.two_sends));
    qcmd.pop = (state == S_POP);
    qcmd.ent = (act == ACT_ENQUEUE) ? new_ent : ret_ent;
  end

  pfts_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (qcmd),
    .head (head),
    .occ  (occ)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      free_map      <= '1;
      tx_busy       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            from_enq       <= (act == ACT_ENQUEUE);
            res_slot       <= ((act == ACT_ENQUEUE) && any_free) ? free_idx : '0;
            res_tx_slot    <= '0;
            res_tx_len     <= '0;
            res_tx_corrupt <= 1'b0;
            if (act == ACT_ENQUEUE) begin
              if (!any_free) begin
                res_status <= ST_REJECTED;
                state      <= S_DONE;
              end else begin
                free_map[free_idx] <= 1'b0;
                if (tx_busy) begin
                  res_status <= ST_QUEUED;
                  state      <= S_DONE;
                end else begin
                  state <= S_POP;
                end
              end
            end else if (!tx_busy) begin
              res_status <= ST_DONE_IDLE;
              state      <= S_DONE;
            end else if (cur.two_sends) begin
              state <= S_POP;
            end else begin
              free_map[cur.slot] <= 1'b1;
              if (head.valid) begin
                state <= S_POP;
              end else begin
                tx_busy    <= 1'b0;
                res_status <= ST_DONE_IDLE;
                state      <= S_DONE;
              end
            end
          end
        end
        S_POP: begin
          cur            <= head;
          tx_busy        <= 1'b1;
          res_tx_slot    <= head.slot;
          res_tx_len     <= head.len;
          res_tx_corrupt <= head.two_sends;
          res_status     <= from_enq ? ST_QUEUED_STARTED : ST_DONE_STARTED;
          state          <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {5'b0, res_tx_corrupt, res_tx_len, res_tx_slot, res_slot};
            m_axis_tuser  <= res_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Outside the pop state, every slot is free, queued or transmitting, and only one of these.
  a_slot_conservation: assert property (@(posedge clk) disable iff (rst)
    (state != S_POP) |->
      (($countones(free_map) + $countones(occ) + 32'(tx_busy)) == SLOTS))
    else $error("slot accounting broken");

  a_busy_not_free: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) && tx_busy) |-> !free_map[cur.slot])
    else $error("transmitting slot marked free");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> head.valid)
    else $error("pop from an empty queue");

  a_queue_packed: assert property (@(posedge clk) disable iff (rst)
    ((occ >> 1) & ~occ) == '0)
    else $error("queue cells not packed toward the head");

endmodule

`default_nettype wire
